// ===== rtl/core/priority_timer_event_queue_assert.svh =====
// Assertion macros for the queue RTL (included by priority_timer_event_queue).
`ifndef PRIORITY_TIMER_EVENT_QUEUE_ASSERT_SVH
`define PRIORITY_TIMER_EVENT_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PTQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PTQ_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PTQ_ASSERT(lbl, prop, msg)

`define PTQ_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/core/ptq_pkg.sv =====
package ptq_pkg;

    localparam int PTQ_DEPTH = 16;
    localparam logic [19:0] PTQ_WINDOW_RESET = 20'd5000;

    typedef struct packed {
        logic [31:0] ev_time;
        logic [7:0]  ev_pri;
        logic [7:0]  ev_kind;
        logic [15:0] ev_tag;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_REMOVE,
        CELL_INSERT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        entry_t     ent;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        RK_QUEUED   = 3'd0,
        RK_DUE      = 3'd1,
        RK_ARM      = 3'd2,
        RK_DISPATCH = 3'd3,
        RK_OVERFLOW = 3'd4,
        RK_PAST     = 3'd5
    } rk_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET_RM,
        S_SET_INS,
        S_SET_HEAD,
        S_SRV_CHK,
        S_SCAN,
        S_DISP,
        S_FINAL
    } state_t;

    typedef struct packed {
        logic        op;
        logic [31:0] now_time;
        logic [31:0] event_time;
        logic [7:0]  event_priority;
        logic [7:0]  event_kind;
        logic [15:0] event_tag;
        logic [7:0]  running_priority;
    } req_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] out_time;
        logic [7:0]  out_priority;
        logic [7:0]  out_kind;
        logic [15:0] out_tag;
        logic [31:0] arm_interval;
        logic [3:0]  slot;
        logic        last;
    } rsp_t;

endpackage

// ===== rtl/core/priority_timer_event_queue.sv =====
// Sorted timer event queue with priority dispatch.
// req channel (req_valid/req_stall/req): one item per set or service request.
// rsp channel (rsp_valid/rsp_stall/rsp): one or more result items per request;
// the final one carries last = 1. A service whose head priority does not beat
// the running priority gives no result at all.
// The queue is a row of cells, one per entry, shifting towards the head on
// removal and away from it on insertion.
// Set: match and remove, insert, report, one state each (S_SET_RM, S_SET_INS,
// S_SET_HEAD); the next item can be taken in the cycle after the result is loaded.
// Service: a check state, then per dispatch a scan over the occupied cells (one
// cell a cycle through a shared compare) and a state to issue and remove; a
// final state reports the arm interval or past due.
// req_stall is high while a request is in work; the output register lets the
// next request in while the last result still waits.
// A stalled receiver holds the block at the next result until taken.
// Reset empties the queue and sets window_reg to 5000; entry contents are
// not cleared.
module priority_timer_event_queue
    import ptq_pkg::*;
#(
    parameter int QUEUE_DEPTH = PTQ_DEPTH,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
    localparam int IDX_W = $clog2(QUEUE_DEPTH)
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    req_t             req_reg;
    logic [32:0]      cutoff_reg;
    logic [7:0]       pri_use_reg, pri_use_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             found_reg, found_next;
    entry_t           best_reg, best_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [19:0]      window_reg;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    cell_cmd_t        cmd;
    logic [IDX_W-1:0] rm_idx;
    entry_t           cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_hit;
    logic [QUEUE_DEPTH-1:0] cell_match;

    logic             can_load;
    logic             load;
    logic             any_match;
    logic [IDX_W-1:0] match_idx;
    logic [7:0]       match_pri;
    logic [IDX_W-1:0] ins_pos;
    entry_t           head;
    entry_t           scan_ent;
    logic             scan_take;
    logic             scan_last;
    logic             head_due;
    logic             head_later;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_h;
            if (g == 0)
            begin : g_first
                assign left_e = '0;
                assign left_h = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = cell_entry[g-1];
                assign left_h = cell_hit[g-1];
            end
            if (g == QUEUE_DEPTH - 1)
            begin : g_end
                assign right_e = cell_entry[g];
            end
            else
            begin : g_inner
                assign right_e = cell_entry[g+1];
            end
            ptq_cell #(
                .QUEUE_DEPTH (QUEUE_DEPTH),
                .IDX         (g)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .count       (count_reg),
                .rm_idx      (rm_idx),
                .left_entry  (left_e),
                .left_hit    (left_h),
                .right_entry (right_e),
                .entry       (cell_entry[g]),
                .hit         (cell_hit[g]),
                .match       (cell_match[g])
            );
        end
    endgenerate

    // lowest matching cell and its priority
    always_comb
    begin
        any_match = 1'b0;
        match_idx = '0;
        match_pri = '0;
        for (int j = 0; j < QUEUE_DEPTH; j++)
        begin
            if (cell_match[j] && !any_match)
            begin
                match_idx = IDX_W'(j);
                match_pri = cell_entry[j].ev_pri;
            end
            any_match = any_match | cell_match[j];
        end
    end

    // hits form a suffix; the insertion point is its first cell
    always_comb
    begin
        ins_pos = '0;
        for (int j = QUEUE_DEPTH - 1; j >= 0; j--)
        begin
            if (cell_hit[j])
            begin
                ins_pos = IDX_W'(j);
            end
        end
    end

    assign head       = cell_entry[0];
    assign scan_ent   = cell_entry[scan_idx_reg];
    assign scan_take  = ({1'b0, scan_ent.ev_time} < cutoff_reg)
                        && (scan_ent.ev_pri > best_reg.ev_pri);
    assign scan_last  = scan_idx_reg == IDX_W'(count_reg - 1'b1);
    assign head_due   = {1'b0, head.ev_time} < cutoff_reg;
    assign head_later = head.ev_time > req_reg.now_time;
    assign can_load   = !rsp_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = req.op ? S_SRV_CHK : S_SET_RM;
                end
            end
            S_SET_RM:
            begin
                if (any_match || count_reg != FULL)
                begin
                    state_next = S_SET_INS;
                end
                else if (can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SET_INS:
            begin
                state_next = S_SET_HEAD;
            end
            S_SET_HEAD:
            begin
                if (can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SRV_CHK:
            begin
                if (count_reg == '0)
                begin
                    if (can_load)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (head.ev_pri <= req_reg.running_priority)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = (found_reg || scan_take) ? S_DISP : S_FINAL;
                end
            end
            S_DISP:
            begin
                if (can_load)
                begin
                    state_next = (count_reg == CNT_W'(1)) ? S_IDLE : S_SCAN;
                end
            end
            S_FINAL:
            begin
                if (can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and cell commands
    always_comb
    begin
        cmd.mode       = CELL_HOLD;
        cmd.ent        = '{ev_time: req_reg.event_time, ev_pri: pri_use_reg,
                           ev_kind: req_reg.event_kind, ev_tag: req_reg.event_tag};
        rm_idx         = '0;
        count_next     = count_reg;
        pri_use_next   = pri_use_reg;
        pos_next       = pos_reg;
        scan_idx_next  = scan_idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        load           = 1'b0;
        rsp_next       = '0;
        unique case (state_reg)
            S_SET_RM:
            begin
                if (any_match)
                begin
                    cmd.mode     = CELL_REMOVE;
                    rm_idx       = match_idx;
                    count_next   = count_reg - 1'b1;
                    pri_use_next = match_pri;
                end
                else if (count_reg == FULL)
                begin
                    load                 = can_load;
                    rsp_next.result_kind = RK_OVERFLOW;
                    rsp_next.last        = 1'b1;
                end
                else
                begin
                    pri_use_next = req_reg.event_priority;
                end
            end
            S_SET_INS:
            begin
                cmd.mode   = CELL_INSERT;
                count_next = count_reg + 1'b1;
                pos_next   = ins_pos;
            end
            S_SET_HEAD:
            begin
                load          = can_load;
                rsp_next.last = 1'b1;
                if (pos_reg != '0)
                begin
                    rsp_next.result_kind = RK_QUEUED;
                    rsp_next.slot        = 4'(pos_reg);
                end
                else if (head_due)
                begin
                    rsp_next.result_kind = RK_DUE;
                end
                else if (head_later)
                begin
                    rsp_next.result_kind  = RK_ARM;
                    rsp_next.arm_interval = head.ev_time - req_reg.now_time;
                end
                else
                begin
                    rsp_next.result_kind = RK_PAST;
                end
            end
            S_SRV_CHK:
            begin
                scan_idx_next   = '0;
                found_next      = 1'b0;
                best_next       = '0;
                if (count_reg == '0)
                begin
                    load                 = can_load;
                    rsp_next.result_kind = RK_PAST;
                    rsp_next.last        = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (scan_take)
                begin
                    best_next     = scan_ent;
                    best_idx_next = scan_idx_reg;
                    found_next    = 1'b1;
                end
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            S_DISP:
            begin
                load                  = can_load;
                rsp_next.result_kind  = RK_DISPATCH;
                rsp_next.out_time     = best_reg.ev_time;
                rsp_next.out_priority = best_reg.ev_pri;
                rsp_next.out_kind     = best_reg.ev_kind;
                rsp_next.out_tag      = best_reg.ev_tag;
                rsp_next.last         = count_reg == CNT_W'(1);
                if (can_load)
                begin
                    cmd.mode      = CELL_REMOVE;
                    rm_idx        = best_idx_reg;
                    count_next    = count_reg - 1'b1;
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    best_next     = '0;
                end
            end
            S_FINAL:
            begin
                load          = can_load;
                rsp_next.last = 1'b1;
                if (head_later)
                begin
                    rsp_next.result_kind  = RK_ARM;
                    rsp_next.arm_interval = head.ev_time - req_reg.now_time;
                end
                else
                begin
                    rsp_next.result_kind = RK_PAST;
                end
            end
            default:
            begin
                cmd.mode = CELL_HOLD;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            window_reg    <= PTQ_WINDOW_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (psel && penable && pwrite && paddr[2] == 1'b0)
            begin
                window_reg <= pwdata[19:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            req_reg    <= req;
            cutoff_reg <= {1'b0, req.now_time} + {13'd0, window_reg};
        end
        pri_use_reg  <= pri_use_next;
        pos_reg      <= pos_next;
        scan_idx_reg <= scan_idx_next;
        found_reg    <= found_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == 1'b0) ? {12'd0, window_reg} : 32'd0;

`include "priority_timer_event_queue_assert.svh"

    `PTQ_NEVER(a_count_bound, count_reg > FULL, "entry count beyond depth")
    `PTQ_ASSERT(a_insert_grows, state_reg == S_SET_INS |=> count_reg == $past(count_reg) + 1'b1, "insert did not grow queue")
    `PTQ_ASSERT(a_disp_shrinks, state_reg == S_DISP && can_load |=> count_reg == $past(count_reg) - 1'b1, "dispatch did not shrink queue")
    `PTQ_NEVER(a_scan_nonempty, state_reg == S_SCAN && count_reg == '0, "scan over empty queue")

endmodule

// ===== rtl/core/ptq_cell.sv =====
module ptq_cell
    import ptq_pkg::*;
#(
    parameter int QUEUE_DEPTH = PTQ_DEPTH,
    parameter int IDX = 0,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
    localparam int IDX_W = $clog2(QUEUE_DEPTH)
)
(
    input  logic             clk,
    input  cell_cmd_t        cmd,
    input  logic [CNT_W-1:0] count,
    input  logic [IDX_W-1:0] rm_idx,
    input  entry_t           left_entry,
    input  logic             left_hit,
    input  entry_t           right_entry,
    output entry_t           entry,
    output logic             hit,
    output logic             match
);

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;

    assign occupied = MY_POS < count;
    assign match    = occupied && (entry_reg.ev_kind == cmd.ent.ev_kind)
                      && (entry_reg.ev_tag == cmd.ent.ev_tag);
    // insertion point and everything after it
    assign hit      = !occupied || (cmd.ent.ev_time < entry_reg.ev_time);
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.mode)
            CELL_REMOVE:
            begin
                if (CNT_W'(rm_idx) <= MY_POS)
                begin
                    entry_next = right_entry;
                end
            end
            CELL_INSERT:
            begin
                if (left_hit)
                begin
                    entry_next = left_entry;
                end
                else if (hit)
                begin
                    entry_next = cmd.ent;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== dv/tb_priority_timer_event_queue.sv =====
import ptq_pkg::*;

class timer_queue_scoreboard;
    entry_t      slots[PTQ_DEPTH];
    int unsigned fill;
    logic [19:0] window;
    rsp_t        expected_results[$];
    int          errors;

    function new();
        fill = 0;
        window = PTQ_WINDOW_RESET;
        errors = 0;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    task report(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        errors++;
    endtask

    function rsp_t make_result(rk_t kind, logic [31:0] interval, logic [3:0] pos);
        rsp_t r;
        r = '0;
        r.result_kind = kind;
        r.arm_interval = interval;
        r.slot = pos;
        r.last = 1'b1;
        return r;
    endfunction

    function void remove_entry(int unsigned p);
        for (int unsigned i = p; i + 1 < fill; i++)
            slots[i] = slots[i + 1];
        fill--;
    endfunction

    function int unsigned insert_entry(entry_t e);
        int unsigned i;
        for (i = 0; i < fill; i++)
            if (e.ev_time < slots[i].ev_time)
                break;
        for (int unsigned j = fill; j > i; j--)
            slots[j] = slots[j - 1];
        slots[i] = e;
        fill++;
        return i;
    endfunction

    function void note_request(req_t q);
        logic [32:0] cutoff;
        entry_t      e;
        rsp_t        d;
        int unsigned pos;
        int          hit;
        int          best;
        logic [7:0]  best_pri;
        int          dispatched;

        cutoff = {1'b0, q.now_time} + window;
        if (q.op == 1'b0) begin
            hit = -1;
            for (int i = 0; i < fill; i++)
                if (hit < 0 && slots[i].ev_kind == q.event_kind && slots[i].ev_tag == q.event_tag)
                    hit = i;
            e = '{q.event_time, q.event_priority, q.event_kind, q.event_tag};
            if (hit >= 0) begin
                e.ev_pri = slots[hit].ev_pri;
                remove_entry(hit);
            end else if (fill >= PTQ_DEPTH) begin
                expected_results.push_back(make_result(RK_OVERFLOW, '0, '0));
                return;
            end
            pos = insert_entry(e);
            if (pos != 0)
                expected_results.push_back(make_result(RK_QUEUED, '0, pos[3:0]));
            else if ({1'b0, slots[0].ev_time} < cutoff)
                expected_results.push_back(make_result(RK_DUE, '0, '0));
            else if (slots[0].ev_time > q.now_time)
                expected_results.push_back(
                    make_result(RK_ARM, slots[0].ev_time - q.now_time, '0));
            else
                expected_results.push_back(make_result(RK_PAST, '0, '0));
            return;
        end

        if (fill == 0) begin
            expected_results.push_back(make_result(RK_PAST, '0, '0));
            return;
        end
        if (slots[0].ev_pri <= q.running_priority)
            return;
        dispatched = 0;
        forever begin
            best = -1;
            best_pri = 0;
            for (int i = 0; i < fill; i++)
                if ({1'b0, slots[i].ev_time} < cutoff && slots[i].ev_pri > best_pri) begin
                    best = i;
                    best_pri = slots[i].ev_pri;
                end
            if (best < 0)
                break;
            d = '0;
            d.result_kind = RK_DISPATCH;
            d.out_time = slots[best].ev_time;
            d.out_priority = slots[best].ev_pri;
            d.out_kind = slots[best].ev_kind;
            d.out_tag = slots[best].ev_tag;
            expected_results.push_back(d);
            dispatched++;
            remove_entry(best);
        end
        if (fill > 0) begin
            if (slots[0].ev_time > q.now_time)
                expected_results.push_back(
                    make_result(RK_ARM, slots[0].ev_time - q.now_time, '0));
            else
                expected_results.push_back(make_result(RK_PAST, '0, '0));
        end else if (dispatched > 0) begin
            expected_results[$].last = 1'b1;
        end
    endfunction

    task check_result(rsp_t got);
        rsp_t e;
        if (expected_results.size() == 0) begin
            report($sformatf("unexpected result %p", got));
            return;
        end
        e = expected_results.pop_front();
        if (got.result_kind !== e.result_kind)
            report($sformatf("result_kind %0d, want %0d", got.result_kind, e.result_kind));
        if (got.out_time !== e.out_time)
            report($sformatf("out_time %0h, want %0h", got.out_time, e.out_time));
        if (got.out_priority !== e.out_priority)
            report($sformatf("out_priority %0d, want %0d", got.out_priority, e.out_priority));
        if (got.out_kind !== e.out_kind)
            report($sformatf("out_kind %0d, want %0d", got.out_kind, e.out_kind));
        if (got.out_tag !== e.out_tag)
            report($sformatf("out_tag %0h, want %0h", got.out_tag, e.out_tag));
        if (got.arm_interval !== e.arm_interval)
            report($sformatf("arm_interval %0h, want %0h", got.arm_interval, e.arm_interval));
        if (got.slot !== e.slot)
            report($sformatf("slot %0d, want %0d", got.slot, e.slot));
        if (got.last !== e.last)
            report($sformatf("last %0b, want %0b", got.last, e.last));
    endtask
endclass

module tb_priority_timer_event_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 350;
    localparam int PHASE_ITEMS = 92;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    timer_queue_scoreboard sb;
    int          idle_cycles;
    int          burst_left;
    logic [31:0] now_base;

    priority_timer_event_queue dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        rsp_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Sample at the falling edge: everything driven at the rising edge has settled.
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (rsp_valid && !rsp_stall)
                sb.check_result(rsp);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off to back the queue up.
    initial
    begin
        int seg;
        int mode;
        int len;
        seg = 0;
        @(posedge rst_n);
        forever begin
            seg++;
            if (seg == 12) begin
                rsp_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end else begin
                mode = $urandom_range(0, 2);
                len = $urandom_range(5, 60);
                repeat (len) begin
                    @(posedge clk);
                    case (mode)
                        0: rsp_stall <= 1'b0;
                        1: rsp_stall <= ($urandom_range(0, 1) == 1);
                        default: rsp_stall <= ($urandom_range(0, 9) < 8);
                    endcase
                end
            end
        end
    end

    // Called in rising-edge context; leaves valid high while a burst goes on.
    task send_request(req_t r);
        logic taken;
        req <= r;
        req_valid <= 1'b1;
        do begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end while (!taken);
        sb.note_request(r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 8);
            if ($urandom_range(0, 2) != 0) begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task write_window(logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.window = value[19:0];
        @(posedge clk);
    endtask

    // Let outstanding results arrive, then allow for a silent service in flight.
    task settle();
        req_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function req_t build(logic op, logic [31:0] now_t, logic [31:0] ev_t, logic [7:0] pri,
                         logic [7:0] kind, logic [15:0] tag, logic [7:0] run_pri);
        req_t r;
        r = '{op, now_t, ev_t, pri, kind, tag, run_pri};
        return r;
    endfunction

    function req_t random_request();
        req_t        r;
        logic [31:0] span;
        r.op = ($urandom_range(0, 9) < 3);
        case ($urandom_range(0, 19))
            0: r.now_time = $urandom();
            1: r.now_time = '1;
            2: r.now_time = '0;
            default: r.now_time = now_base + $urandom_range(0, 50);
        endcase
        span = {12'd0, sb.window};
        case ($urandom_range(0, 9))
            0: r.event_time = $urandom();
            1: r.event_time = r.now_time;
            2: r.event_time = r.now_time + $urandom_range(0, 10) - 5;
            default: r.event_time = r.now_time + $urandom_range(0, 2 * span + 20) - span / 2;
        endcase
        r.event_priority = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        // Mostly a small key pool so retimes and a full queue both happen.
        if ($urandom_range(0, 4) != 0) begin
            r.event_kind = 8'($urandom_range(0, 3));
            r.event_tag = 16'($urandom_range(0, 4));
        end else begin
            r.event_kind = 8'($urandom());
            r.event_tag = 16'($urandom());
        end
        r.running_priority = ($urandom_range(0, 9) < 6) ? 8'd0 : 8'($urandom_range(0, 255));
        if (r.op)
            now_base = now_base + $urandom_range(0, span + 100);
        return r;
    endfunction

    initial
    begin
        logic [31:0] windows[5];
        burst_left = 0;
        idle_cycles = 0;
        windows = '{32'd5000, 32'd0, 32'd1000000, 32'hFFFF_FFFF, 32'd0};
        windows[4] = $urandom_range(0, 1000000);
        @(posedge rst_n);
        @(posedge clk);
        for (int ph = 0; ph < 5; ph++) begin
            write_window(windows[ph]);
            if (ph == 0) begin
                send_request(build(1'b1, 32'd0, 32'd0, 8'd0, 8'd0, 16'd0, 8'd0));
                send_request(build(1'b0, 32'd0, 32'd100000, 8'd5, 8'd1, 16'd1, 8'd0));
                send_request(build(1'b0, 32'd0, 32'd200000, 8'd9, 8'd2, 16'd2, 8'd0));
                send_request(build(1'b0, 32'd0, 32'd100000, 8'd255, 8'd3, 16'd3, 8'd0));
                // retime moves an entry to the head, keeping its priority
                send_request(build(1'b0, 32'd0, 32'd10, 8'd77, 8'd2, 16'd2, 8'd0));
                send_request(build(1'b1, 32'd0, 32'd0, 8'd0, 8'd0, 16'd0, 8'd255));
                send_request(build(1'b0, 32'd0, 32'd0, 8'd0, 8'd4, 16'd4, 8'd0));
                send_request(build(1'b1, 32'd0, 32'd0, 8'd0, 8'd0, 16'd0, 8'd0));
                send_request(build(1'b0, 32'd0, 32'd300000, 8'd0, 8'd4, 16'd4, 8'd0));
                send_request(build(1'b1, 32'd200000, 32'd0, 8'd0, 8'd0, 16'd0, 8'd0));
                send_request(build(1'b0, '1, '1, 8'd255, 8'd255, 16'hFFFF, 8'd0));
                for (int k = 0; k < 17; k++)
                    send_request(build(1'b0, 32'd1000, 32'd900000 + k, 8'(k + 1),
                                       8'(k + 16), 16'(k), 8'd0));
                send_request(build(1'b1, '1, '0, 8'd0, 8'd0, 16'd0, 8'd0));
            end
            now_base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 : $urandom_range(0, 1 << 30);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(random_request());
            settle();
        end
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ptq_pkg.sv
rtl/core/ptq_cell.sv
rtl/core/priority_timer_event_queue.sv
dv/tb_priority_timer_event_queue.sv
